FILE: hw/rtl/lsmt_pkg.sv
// shared types and constants for the lcd scanline mode timer
`timescale 1ns / 1ps

package lsmt_pkg;

    localparam int unsigned CYCLES_W = 8;
    localparam int unsigned LINE_W   = 8;
    localparam int unsigned LC_W     = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [LC_W-1:0] LINE_LEN     = 10'd456;
    localparam logic [LC_W-1:0] RENDER_AFTER = 10'd252;
    localparam logic [LC_W-1:0] OAM_END      = 10'd81;
    localparam logic [LC_W-1:0] DRAW_END     = 10'd253;
    localparam logic [LC_W-1:0] HBLANK_END   = 10'd457;

    localparam logic [LINE_W-1:0] RENDER_LINE_LIMIT = 8'd145;
    localparam logic [LINE_W-1:0] VBLANK_LINE       = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE         = 8'd154;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_COMPARE = 2'd0,
        CFG_CMP_IRQ_EN   = 2'd1,
        CFG_DISP_EN      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [LINE_W-1:0] line_compare;
        logic              compare_irq_enable;
        logic              display_enable;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              vblank_irq;
        logic              status_irq;
        logic              render_line;
        logic [LINE_W-1:0] render_row;
        logic              draw_frame;
    } t_result;

endpackage

FILE: hw/rtl/lsmt_cfg.sv
// configuration register file for the lcd scanline mode timer
`timescale 1ns / 1ps

module lsmt_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lsmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsmt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lsmt_pkg::t_cfg                  o_cfg
);

    lsmt_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (lsmt_pkg::t_cfg_idx'(i_cfg_index))
                lsmt_pkg::CFG_LINE_COMPARE: begin
                    r_cfg.line_compare <= i_cfg_data[lsmt_pkg::LINE_W-1:0];
                end
                lsmt_pkg::CFG_CMP_IRQ_EN: begin
                    r_cfg.compare_irq_enable <= i_cfg_data[0];
                end
                lsmt_pkg::CFG_DISP_EN: begin
                    r_cfg.display_enable <= i_cfg_data[0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/lsmt_core.sv
// line timing state and per-transaction next-state logic
`timescale 1ns / 1ps

module lsmt_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [lsmt_pkg::CYCLES_W-1:0] i_cycles,
    input  lsmt_pkg::t_cfg                i_cfg,
    output lsmt_pkg::t_result             o_result
);

    logic [lsmt_pkg::LC_W-1:0]   r_line_cycles, n_line_cycles;
    logic [lsmt_pkg::LINE_W-1:0] r_scanline, n_scanline;
    lsmt_pkg::t_mode             r_mode, n_mode;
    logic                        r_coinc, n_coinc;
    logic                        r_rendered, n_rendered;
    logic                        r_presented, n_presented;

    always_comb begin
        logic [lsmt_pkg::LC_W-1:0]   lc;
        logic [lsmt_pkg::LINE_W-1:0] scan;

        lc   = r_line_cycles + {{(lsmt_pkg::LC_W-lsmt_pkg::CYCLES_W){1'b0}}, i_cycles};
        scan = r_scanline;

        n_rendered  = r_rendered;
        n_presented = r_presented;
        n_coinc     = r_coinc;
        o_result    = '0;

        // one render strobe per visible line, line 144 included
        if (lc > lsmt_pkg::RENDER_AFTER && scan < lsmt_pkg::RENDER_LINE_LIMIT
                && !r_rendered) begin
            o_result.render_line = 1'b1;
            o_result.render_row  = scan;
            n_rendered           = 1'b1;
        end

        // mode from position in line, held past the end of the line; vblank from line 144 on
        if (lc < lsmt_pkg::OAM_END) begin
            n_mode = lsmt_pkg::MODE_OAM;
        end else if (lc < lsmt_pkg::DRAW_END) begin
            n_mode = lsmt_pkg::MODE_DRAW;
        end else if (lc < lsmt_pkg::HBLANK_END) begin
            n_mode = lsmt_pkg::MODE_HBLANK;
        end else begin
            n_mode = r_mode;
        end
        if (scan >= lsmt_pkg::VBLANK_LINE) begin
            n_mode = lsmt_pkg::MODE_VBLANK;
        end

        // once per frame
        if (!r_presented && scan > lsmt_pkg::VBLANK_LINE) begin
            o_result.vblank_irq = 1'b1;
            o_result.draw_frame = i_cfg.display_enable;
            n_presented         = 1'b1;
        end

        // end of line
        if (lc > lsmt_pkg::LINE_LEN) begin
            lc         = lc - lsmt_pkg::LINE_LEN;
            scan       = scan + 1'b1;
            n_rendered = 1'b0;
        end

        // compare runs before the wrap
        if (scan == i_cfg.line_compare) begin
            if (i_cfg.compare_irq_enable && !r_coinc) begin
                o_result.status_irq = 1'b1;
                n_coinc             = 1'b1;
            end
        end else begin
            n_coinc = 1'b0;
        end

        if (scan > lsmt_pkg::LAST_LINE) begin
            scan        = '0;
            n_presented = 1'b0;
        end

        n_line_cycles        = lc;
        n_scanline           = scan;
        o_result.mode        = n_mode;
        o_result.line        = scan;
        o_result.coincidence = n_coinc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_cycles <= '0;
            r_scanline    <= '0;
            r_mode        <= lsmt_pkg::MODE_HBLANK;
            r_coinc       <= 1'b0;
            r_rendered    <= 1'b0;
            r_presented   <= 1'b0;
        end else if (i_step) begin
            r_line_cycles <= n_line_cycles;
            r_scanline    <= n_scanline;
            r_mode        <= n_mode;
            r_coinc       <= n_coinc;
            r_rendered    <= n_rendered;
            r_presented   <= n_presented;
        end
    end

endmodule

FILE: hw/rtl/lcd_scanline_mode_timer_top.sv
// top level of the lcd scanline mode timer
`timescale 1ns / 1ps

// lcd scanline and display mode timer
// - input channel: one transaction carries the machine cycles elapsed since the
//   previous one; the block adds them to the line counter and advances the line
// - output channel: exactly one result transaction per input transaction, in
//   order: mode, line, coincidence flag, interrupt pulses and render strobes
// - config channel: index 0 line compare, 1 compare interrupt enable,
//   2 display enable; always ready, other indexes are dropped; write only
//   while no transaction is in flight
// - path: an accepted transaction loads the input register; its result is
//   computed from it and loaded into the result register when that slot is free
// - throughput: one transaction per cycle unless the receiver stalls; the line
//   state is read and written back between the two registers
// - stall: while the receiver holds ready low the result register holds; the
//   input register still takes one more transaction if empty, then ready drops
// - reset: synchronous, active low; clears line counter, line, mode (hblank),
//   flags, config registers and both valid bits
module lcd_scanline_mode_timer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lsmt_pkg::CYCLES_W-1:0]   i_cycles,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_mode,
    output logic [lsmt_pkg::LINE_W-1:0]     o_line,
    output logic                            o_coincidence,
    output logic                            o_vblank_irq,
    output logic                            o_status_irq,
    output logic                            o_render_line,
    output logic [lsmt_pkg::LINE_W-1:0]     o_render_row,
    output logic                            o_draw_frame,
    // config channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lsmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsmt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lsmt_pkg::t_cfg    cfg;
    lsmt_pkg::t_result step_result;

    // input register
    logic                          r_in_valid;
    logic [lsmt_pkg::CYCLES_W-1:0] r_cycles;
    // result register
    logic                          r_out_valid;
    lsmt_pkg::t_result             r_result;

    logic out_free;
    logic step;

    // result slot is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    lsmt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsmt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cycles (r_cycles),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cycles <= i_cycles;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mode        = r_result.mode;
    assign o_line        = r_result.line;
    assign o_coincidence = r_result.coincidence;
    assign o_vblank_irq  = r_result.vblank_irq;
    assign o_status_irq  = r_result.status_irq;
    assign o_render_line = r_result.render_line;
    assign o_render_row  = r_result.render_row;
    assign o_draw_frame  = r_result.draw_frame;

`ifndef SYNTHESIS
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_line <= lsmt_pkg::LAST_LINE)
        else $error("line beyond last line");

    a_vblank_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line > lsmt_pkg::VBLANK_LINE) |-> o_mode == lsmt_pkg::MODE_VBLANK)
        else $error("mode not vblank in vertical blank");

    a_render_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_render_line) |-> o_render_row < lsmt_pkg::RENDER_LINE_LIMIT)
        else $error("render strobe for invisible row");

    a_draw_with_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_draw_frame) |-> (o_vblank_irq && cfg.display_enable))
        else $error("frame strobe without vblank interrupt");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed transaction lost");
`endif

endmodule

FILE: tb/lcd_scanline_mode_timer_top_test.sv
// self-checking testbench for the lcd scanline mode timer
`timescale 1ns / 1ps

import lsmt_pkg::*;

class scanline_scoreboard;

    // register copies
    logic [LINE_W-1:0] cmp_line;
    logic              cmp_irq_en;
    logic              disp_en;

    // line timing state
    logic [LC_W-1:0]   cycle_count;
    logic [LINE_W-1:0] scanline;
    t_mode             mode_now;
    logic              coinc;
    logic              rendered_this_line;
    logic              frame_done;

    t_result pending_status[$];

    int errors;
    int checked;
    int steps;
    int frames;
    int renders;
    int vblanks;
    int draws;
    int compare_hits;

    function new();
        cmp_line           = '0;
        cmp_irq_en         = 1'b0;
        disp_en            = 1'b0;
        cycle_count        = '0;
        scanline           = '0;
        mode_now           = MODE_HBLANK;
        coinc              = 1'b0;
        rendered_this_line = 1'b0;
        frame_done         = 1'b0;
        errors = 0; checked = 0; steps = 0; frames = 0;
        renders = 0; vblanks = 0; draws = 0; compare_hits = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LINE_COMPARE: cmp_line   = data;
            CFG_CMP_IRQ_EN:   cmp_irq_en = data[0];
            CFG_DISP_EN:      disp_en    = data[0];
            default: ;
        endcase
    endfunction

    // advance the line timing by one transaction and queue the status it yields
    function void note_step(logic [CYCLES_W-1:0] cycles);
        t_result want;
        want = '0;
        steps++;
        cycle_count = cycle_count + LC_W'(cycles);

        if (cycle_count > RENDER_AFTER && scanline < RENDER_LINE_LIMIT
                && !rendered_this_line) begin
            want.render_line   = 1'b1;
            want.render_row    = scanline;
            rendered_this_line = 1'b1;
            renders++;
        end

        // past the end of the line the mode keeps its last value
        if (cycle_count < OAM_END)
            mode_now = MODE_OAM;
        else if (cycle_count < DRAW_END)
            mode_now = MODE_DRAW;
        else if (cycle_count < HBLANK_END)
            mode_now = MODE_HBLANK;
        if (scanline >= VBLANK_LINE)
            mode_now = MODE_VBLANK;

        if (!frame_done && scanline > VBLANK_LINE) begin
            want.vblank_irq = 1'b1;
            want.draw_frame = disp_en;
            frame_done      = 1'b1;
            vblanks++;
            if (disp_en) draws++;
        end

        if (cycle_count > LINE_LEN) begin
            cycle_count        = cycle_count - LINE_LEN;
            scanline           = scanline + 1'b1;
            rendered_this_line = 1'b0;
        end

        // compare runs before the wrap, so line 155 can match once
        if (scanline == cmp_line) begin
            if (cmp_irq_en && !coinc) begin
                want.status_irq = 1'b1;
                coinc           = 1'b1;
                compare_hits++;
            end
        end else begin
            coinc = 1'b0;
        end

        if (scanline > LAST_LINE) begin
            scanline   = '0;
            frame_done = 1'b0;
            frames++;
        end

        want.mode        = mode_now;
        want.line        = scanline;
        want.coincidence = coinc;
        pending_status.push_back(want);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("mismatch at result %0d (%0t): %s", checked, $time, msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(t_result got);
        t_result want;
        checked++;
        if (pending_status.size() == 0) begin
            report_mismatch("result with no status expected");
            return;
        end
        want = pending_status.pop_front();
        compare_field("mode",        8'(got.mode),        8'(want.mode));
        compare_field("line",        got.line,            want.line);
        compare_field("coincidence", 8'(got.coincidence), 8'(want.coincidence));
        compare_field("vblank_irq",  8'(got.vblank_irq),  8'(want.vblank_irq));
        compare_field("status_irq",  8'(got.status_irq),  8'(want.status_irq));
        compare_field("render_line", 8'(got.render_line), 8'(want.render_line));
        compare_field("render_row",  got.render_row,      want.render_row);
        compare_field("draw_frame",  8'(got.draw_frame),  8'(want.draw_frame));
    endtask

endclass

module lcd_scanline_mode_timer_top_test;

    // index past the last register, must be dropped by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // stretches where neither side idles (counted in transactions)
    localparam int CALM_FIRST = 250;
    localparam int CALM_LAST  = 450;

    // result count at which the receiver holds off, and for how many cycles
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 80;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CYCLES_W-1:0]   i_cycles;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_mode;
    logic [LINE_W-1:0]     o_line;
    logic                  o_coincidence;
    logic                  o_vblank_irq;
    logic                  o_status_irq;
    logic                  o_render_line;
    logic [LINE_W-1:0]     o_render_row;
    logic                  o_draw_frame;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    scanline_scoreboard board;
    int                 items_sent;

    lcd_scanline_mode_timer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cycles      (i_cycles),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mode        (o_mode),
        .o_line        (o_line),
        .o_coincidence (o_coincidence),
        .o_vblank_irq  (o_vblank_irq),
        .o_status_irq  (o_status_irq),
        .o_render_line (o_render_line),
        .o_render_row  (o_render_row),
        .o_draw_frame  (o_draw_frame),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // offer one transaction, with a random idle gap before it; valid is only
    // lowered when a gap follows, so it never drops and rises in one step
    task automatic send_cycles(input logic [CYCLES_W-1:0] cycles);
        int gap;
        gap = 0;
        if (items_sent < CALM_FIRST || items_sent >= CALM_LAST)
            while ($urandom_range(0, 99) < 16) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cycles   <= cycles;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_step(cycles);
        items_sent++;
    endtask

    // one register write transaction; valid stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.note_config(idx, data);
    endtask

    // all three registers plus a write to the unused index; the one-bit
    // registers get random upper bits that the block must ignore
    task automatic apply_settings(input logic [LINE_W-1:0] cmp_line,
                                  input logic cmp_irq_en, input logic disp_en);
        write_reg(CFG_LINE_COMPARE, cmp_line);
        write_reg(CFG_CMP_IRQ_EN, {7'($urandom), cmp_irq_en});
        write_reg(CFG_DISP_EN, {7'($urandom), disp_en});
        write_reg(CFG_SPARE_IDX, 8'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering and wait until every expected status has come back,
    // then let the two pipeline stages settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // random cycle counts, mostly large so frames go by quickly; either a
    // fixed number of transactions or until the line wraps to zero
    task automatic run_random(input int max_items, input bit to_wrap);
        int                  start_frames;
        int                  n;
        logic [CYCLES_W-1:0] cycles;
        start_frames = board.frames;
        n = 0;
        while (n < max_items && !(to_wrap && board.frames != start_frames)) begin
            if ($urandom_range(0, 3) != 0)
                cycles = CYCLES_W'($urandom_range(150, 255));
            else
                cycles = CYCLES_W'($urandom_range(0, 255));
            send_cycles(cycles);
            n++;
        end
    endtask

    // receiver: checks each accepted result, then picks ready for the next
    // cycle; one long counted hold-off lets the block back up into its input
    initial begin
        t_result got;
        int      hold;
        bit      fired;
        hold  = 0;
        fired = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.mode        = t_mode'(o_mode);
                got.line        = o_line;
                got.coincidence = o_coincidence;
                got.vblank_irq  = o_vblank_irq;
                got.status_irq  = o_status_irq;
                got.render_line = o_render_line;
                got.render_row  = o_render_row;
                got.draw_frame  = o_draw_frame;
                board.check_result(got);
            end
            if (!fired && board.checked == HOLD_AT) begin
                hold  = HOLD_CYCLES;
                fired = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (board.checked >= CALM_FIRST && board.checked < CALM_LAST) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // stimulus
    initial begin
        board      = new();
        items_sent = 0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cycles    <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // line 0 matches the reset compare value but the interrupt is off,
        // so the coincidence flag stays clear
        send_cycles(8'd0);
        drain();

        // enabling it raises the status pulse once; a repeated match does not
        apply_settings(8'd0, 1'b1, 1'b0);
        send_cycles(8'd0);
        send_cycles(8'd80);     // last oam cycle
        drain();

        // with the interrupt off again the flag holds while the line matches
        apply_settings(8'd0, 1'b0, 1'b1);
        send_cycles(8'd1);      // 81: drawing starts
        send_cycles(8'd171);    // 252: still drawing, no render yet
        send_cycles(8'd1);      // 253: render strobe, hblank
        send_cycles(8'd203);    // 456: end of line, no advance
        send_cycles(8'd1);      // 457: mode holds, line 1, flag cleared
        drain();

        // compare on line 2 hit while advancing; counter passes the line end
        apply_settings(8'd2, 1'b1, 1'b1);
        send_cycles(8'd255);
        send_cycles(8'd255);
        send_cycles(8'd255);
        send_cycles(8'd146);
        send_cycles(8'd0);      // zero on the line end boundary
        send_cycles(8'd255);
        drain();

        // compare value that no line reaches, plus alternating bit patterns
        apply_settings(8'd255, 1'b1, 1'b0);
        send_cycles(8'd0);
        send_cycles(8'd128);
        send_cycles(8'd127);
        send_cycles(8'd85);
        send_cycles(8'd170);
        drain();

        // full frame with compare on the line that exists only before the
        // wrap, and the frame draw strobe enabled
        apply_settings(8'd155, 1'b1, 1'b1);
        run_random(700, 1'b1);
        drain();

        // next frame: compare on line 0 right after the wrap, draw gated off
        apply_settings(8'd0, 1'b1, 1'b0);
        run_random(700, 1'b1);
        drain();

        // partial frame with random settings
        apply_settings(LINE_W'($urandom_range(1, 60)), 1'($urandom), 1'($urandom));
        run_random(150, 1'b0);
        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d steps, %0d frame wraps, %0d line renders, %0d vblank irqs",
                 board.steps, board.frames, board.renders, board.vblanks);
        $display("with %0d frame draws and %0d compare irqs; %0d results checked",
                 board.draws, board.compare_hits, board.checked);
        if (board.errors == 0) begin
            $display("lcd_scanline_mode_timer_top_test: PASS");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("lcd_scanline_mode_timer_top_test: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", board.pending_status.size());
        $display("lcd_scanline_mode_timer_top_test: FAIL");
        $finish;
    end

endmodule
